### src/uart_command_frame_parser_defines.svh
// Assertion macros for the UART command frame parser.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef UART_COMMAND_FRAME_PARSER_DEFINES_SVH
`define UART_COMMAND_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCFP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ucfp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UCFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ucfp assertion failed");

`endif

### src/ucfp_pkg.sv
// Shared constants, widths and the parameter-letter decoder for the
// UART command frame parser. No dependencies.
package ucfp_pkg;

  // Field widths of one input beat and one result beat.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CntW   = 3;
  localparam int unsigned FieldChars = 7;
  localparam int unsigned CharsW = ByteW * FieldChars;

  // Default limit on collected value characters.
  localparam int unsigned MaxCharsDefault = 7;

  // Frame characters.
  localparam logic [ByteW-1:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [ByteW-1:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [ByteW-1:0] CH_GET   = 8'h67;  // 'g'
  localparam logic [ByteW-1:0] CH_SET   = 8'h73;  // 's'
  localparam logic [ByteW-1:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;  // '9'

  // Parameter codes.
  localparam logic [CodeW-1:0] PARAM_T    = 3'd0;
  localparam logic [CodeW-1:0] PARAM_C    = 3'd1;
  localparam logic [CodeW-1:0] PARAM_H    = 3'd2;
  localparam logic [CodeW-1:0] PARAM_B    = 3'd3;
  localparam logic [CodeW-1:0] PARAM_P    = 3'd4;
  localparam logic [CodeW-1:0] PARAM_I    = 3'd5;
  localparam logic [CodeW-1:0] PARAM_D    = 3'd6;
  localparam logic [CodeW-1:0] PARAM_NONE = 3'd7;

  // Request kinds.
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_SET = 1'b1;

  // Maps a parameter letter to its code. The letter b is only valid in a set.
  function automatic logic [CodeW-1:0] letter_code(input logic [ByteW-1:0] c,
                                                   input logic allow_b);
    logic [CodeW-1:0] code;
    case (c)
      8'h74:   code = PARAM_T;                        // 't'
      8'h63:   code = PARAM_C;                        // 'c'
      8'h68:   code = PARAM_H;                        // 'h'
      8'h62:   code = allow_b ? PARAM_B : PARAM_NONE; // 'b'
      8'h70:   code = PARAM_P;                        // 'p'
      8'h69:   code = PARAM_I;                        // 'i'
      8'h64:   code = PARAM_D;                        // 'd'
      default: code = PARAM_NONE;
    endcase
    return code;
  endfunction

endpackage

### src/uart_command_frame_parser.sv
// UART command frame parser: top level, single module.
// Depends on ucfp_pkg and uart_command_frame_parser_defines.svh.
//
// Usage: received bytes enter on the input channel (in_valid_i, in_ready_o,
// rx_byte_i), one byte per beat. Frames are "#g<p>;" (get) and
// "#s<p><value>;" (set); a '#' restarts framing from any point. When a ';'
// closes a valid frame, one result beat leaves on the output channel
// (out_valid_o, out_ready_i) carrying request_kind_o, param_code_o,
// value_chars_o (first character in the low byte, unused bytes zero) and
// value_count_o. Set values keep up to min(MAX_CHARS, 7) digit or comma
// characters; further ones are dropped. Any other byte ends the frame
// silently.
// Result: registered, valid in the cycle after the ';' beat is accepted.
// Throughput: one byte per cycle when in_ready_o is high; the frame state
// and output register update in the same cycle that a byte is accepted.
// Stall: a held result blocks the input while the receiver stalls;
// in_ready_o is low only while an untaken result sits in the output register
// and the receiver holds out_ready_i low.
// Reset: the parser returns to idle and the output register empties.
module uart_command_frame_parser
  import ucfp_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MaxCharsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              request_kind_o,
  output logic [CodeW-1:0]  param_code_o,
  output logic [CharsW-1:0] value_chars_o,
  output logic [CntW-1:0]   value_count_o
);

`include "uart_command_frame_parser_defines.svh"

  // Characters actually kept; the result field holds at most seven.
  localparam int unsigned Limit = (MAX_CHARS > FieldChars) ? FieldChars : MAX_CHARS;

  // Parse phases.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_READY = 3'd1;
  localparam logic [2:0] PH_GET   = 3'd2;
  localparam logic [2:0] PH_SET   = 3'd3;
  localparam logic [2:0] PH_PARAM = 3'd4;
  localparam logic [2:0] PH_VALUE = 3'd5;

  logic [2:0]       phase_q, phase_d;
  logic [CodeW-1:0] param_q, param_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0] store_q [Limit];

  logic              out_valid_q;
  logic              kind_q;
  logic [CodeW-1:0]  code_q;
  logic [CharsW-1:0] chars_q;
  logic [CntW-1:0]   count_q;

  logic              in_beat;
  logic              wr_en;
  logic              emit;
  logic              kind_d;
  logic [CharsW-1:0] chars_d;
  logic [CntW-1:0]   count_d;
  logic [CodeW-1:0]  letter;
  logic              is_value_char;
  logic [CharsW-1:0] packed_chars;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_beat    = in_valid_i && in_ready_o;

  assign is_value_char = ((rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE)) ||
                         (rx_byte_i == CH_COMMA);

  // The letter b is only legal in the set phase.
  assign letter = letter_code(rx_byte_i, phase_q == PH_SET);

  // Pack the stored characters; entries at or beyond the count read as zero.
  always_comb begin
    packed_chars = '0;
    for (int k = 0; k < Limit; k++) begin
      if (CntW'(k) < cnt_q) begin
        packed_chars[ByteW*k +: ByteW] = store_q[k];
      end
    end
  end

  // Frame state machine and result formation for the accepted beat.
  always_comb begin
    phase_d = phase_q;
    param_d = param_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    emit    = 1'b0;
    kind_d  = KIND_GET;
    chars_d = '0;
    count_d = '0;
    if (in_beat) begin
      if (rx_byte_i == CH_HASH) begin
        phase_d = PH_READY;
      end else begin
        unique case (phase_q)
          PH_READY: begin
            if (rx_byte_i == CH_GET) begin
              phase_d = PH_GET;
            end else if (rx_byte_i == CH_SET) begin
              phase_d = PH_SET;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_GET: begin
            if (letter != PARAM_NONE) begin
              param_d = letter;
              phase_d = PH_PARAM;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_SET: begin
            if (letter != PARAM_NONE) begin
              param_d = letter;
              cnt_d   = '0;
              phase_d = PH_VALUE;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_PARAM: begin
            phase_d = PH_IDLE;
            if (rx_byte_i == CH_SEMI) begin
              emit   = 1'b1;
              kind_d = KIND_GET;
            end
          end
          PH_VALUE: begin
            if (is_value_char) begin
              // Characters past the limit are dropped without leaving the phase.
              if (cnt_q < CntW'(Limit)) begin
                wr_en = 1'b1;
                cnt_d = cnt_q + CntW'(1);
              end
            end else begin
              phase_d = PH_IDLE;
              if (rx_byte_i == CH_SEMI) begin
                emit    = 1'b1;
                kind_d  = KIND_SET;
                chars_d = packed_chars;
                count_d = cnt_q;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      param_q <= PARAM_T;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      param_q <= param_d;
      cnt_q   <= cnt_d;
    end
  end

  // Value character store, one register per slot.
  for (genvar k = 0; k < Limit; k++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (wr_en && (cnt_q == CntW'(k))) begin
        store_q[k] <= rx_byte_i;
      end
    end
  end

  // Output valid: reloaded whenever in_ready_o is high; data loads on emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_beat && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && emit) begin
      kind_q  <= kind_d;
      code_q  <= param_q;
      chars_q <= chars_d;
      count_q <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign request_kind_o = kind_q;
  assign param_code_o   = code_q;
  assign value_chars_o  = chars_q;
  assign value_count_o  = count_q;

  // Checks on the parser's own logic.
  `UCFP_ASSERT_SAME(a_cnt_limit, 1'b1, cnt_q <= CntW'(Limit))
  `UCFP_ASSERT_SAME(a_emit_on_semi, emit, in_beat && (rx_byte_i == CH_SEMI))
  `UCFP_ASSERT_SAME(a_get_empty, out_valid_q && (kind_q == KIND_GET), (count_q == '0) && (chars_q == '0))
  `UCFP_ASSERT_NEXT(a_hash_restart, in_beat && (rx_byte_i == CH_HASH), phase_q == PH_READY)
  `UCFP_ASSERT_NEXT(a_result_loaded, in_beat && emit, out_valid_q)

endmodule
